// ----- sv/wsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants shared by the websocket frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfr_pkg;

    // parser phases, one-hot
    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXT16   = 6'b000100,
        PH_EXT64   = 6'b001000,
        PH_MASK    = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    // event codes reported at the end of a frame or on a header over the length limit
    typedef enum logic [2:0] {
        EVT_DATA        = 3'd0,
        EVT_PING        = 3'd1,
        EVT_CLOSE       = 3'd2,
        EVT_TOO_BIG     = 3'd3,
        EVT_UNSUPPORTED = 3'd4
    } evt_code_t;

    // frame opcodes
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;

    // 7-bit length escapes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // index of the last byte in each multi-byte field
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] MASK_LAST  = 3'd3;

    // reset value of the maximum message length register
    localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

    // result queue between parser and output stage
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // one result command from the parser
    typedef struct packed {
        logic        pv;
        logic [7:0]  raw;
        logic [7:0]  mask;
        logic        ev;
        evt_code_t   code;
        logic [3:0]  opcode;
        logic [31:0] len_lo;
        logic        len_hi;
    } cmd_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ----- sv/websocket_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_receiver_core
// Receive-side websocket frame parser: header, extended length, mask key,
// payload unmasking and per-frame events.
// ----------------------------------------------------------------------------
//
//  channel   signals                         transfer when
//  -------   -----------------------------   --------------------
//  input     push, full, rx_byte             push && !full
//  result    empty, pop, payload/event/...   pop && !empty
//  config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
//  One byte is taken every cycle while full is low; the parser state update is
//  the only loop. A result is formed combinationally in the parser, written
//  into the four-entry queue and then loaded from it into the output register.
//  While pop is held low the queue fills and full rises once it holds four.
//  Reset clears parser state, queue pointers and count and the output valid flag;
//  the length limit returns to 65536 and cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_receiver_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             payload_valid,
    output logic [7:0]       payload_byte,
    output logic             event_valid,
    output logic [2:0]       event_code,
    output logic [3:0]       frame_opcode,
    output logic [31:0]      frame_length,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import wsfr_pkg::*;

    logic       in_fire;
    logic       cmd_valid;
    cmd_t       cmd;
    cmd_t       q_data;
    fifo_stat_t q_stat;
    logic       q_rd;

    assign full      = q_stat.full;
    assign in_fire   = push && !q_stat.full;
    assign cfg_ready = 1'b1;

    // parser
    wsfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // command queue
    wsfr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .stat    (q_stat)
    );

    // output stage
    wsfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_data),
        .q_stat        (q_stat),
        .q_rd          (q_rd),
        .pop           (pop),
        .empty         (empty),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .event_valid   (event_valid),
        .event_code    (event_code),
        .frame_opcode  (frame_opcode),
        .frame_length  (frame_length)
    );

endmodule

`default_nettype wire

// ----- sv/wsfr_front.sv -----
// ----------------------------------------------------------------------------
// wsfr_front
// Byte parser: walks header, extended length and mask key, tracks payload
// progress and issues one result command per byte that causes a result.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          cfg_fire,
    input  wire logic [31:0]   cfg_data,
    output logic               cmd_valid,
    output wsfr_pkg::cmd_t     cmd
);
    import wsfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_en_reg, mask_en_next;
    logic [31:0] len_reg, len_next;
    logic        len_hi_reg, len_hi_next;
    logic [31:0] rem_reg, rem_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  pos_reg, pos_next;
    logic        halted_reg, halted_next;
    logic [31:0] max_len_reg;

    logic        is_data;
    evt_code_t   fin_code;
    logic        fin_halt;
    logic [31:0] ext_lo;
    logic        ext_hi;
    logic [2:0]  ext_last;
    logic [7:0]  key_byte;
    logic [31:0] rem_dec;
    logic        hd_go;
    logic [31:0] hd_lo;
    logic        hd_hi;
    logic        too_big;

    // frame end classification
    assign is_data = (opcode_reg == OPC_TEXT) || (opcode_reg == OPC_BINARY);

    always_comb
    begin
        if (is_data)
        begin
            fin_code = EVT_DATA;
        end
        else if (opcode_reg == OPC_PING)
        begin
            fin_code = EVT_PING;
        end
        else if (opcode_reg == OPC_CLOSE)
        begin
            fin_code = EVT_CLOSE;
        end
        else
        begin
            fin_code = EVT_UNSUPPORTED;
        end
    end

    assign fin_halt = !is_data && (opcode_reg != OPC_PING);

    // extended length shift; bytes leaving the low word set the high flag
    assign ext_lo   = {len_reg[23:0], rx_byte};
    assign ext_hi   = len_hi_reg || (len_reg[31:24] != 8'd0);
    assign ext_last = (phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST;

    // key byte for the current payload position, first byte in the top lane
    assign key_byte = key_reg[{~pos_reg, 3'b000} +: 8];
    assign rem_dec  = (rem_reg != 32'd0) ? (rem_reg - 32'd1) : 32'd0;

    // next state and result command
    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        mask_en_next = mask_en_reg;
        len_next     = len_reg;
        len_hi_next  = len_hi_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        halted_next  = halted_reg;
        cmd_valid    = 1'b0;
        cmd          = '0;
        hd_go        = 1'b0;
        hd_lo        = len_reg;
        hd_hi        = len_hi_reg;
        too_big      = 1'b0;

        if (in_fire && !halted_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mask_en_next = rx_byte[7];
                    cnt_next     = 3'd0;
                    len_hi_next  = 1'b0;
                    if (rx_byte[6:0] == LEN_EXT16)
                    begin
                        phase_next = PH_EXT16;
                        len_next   = 32'd0;
                    end
                    else if (rx_byte[6:0] == LEN_EXT64)
                    begin
                        phase_next = PH_EXT64;
                        len_next   = 32'd0;
                    end
                    else
                    begin
                        len_next = {25'd0, rx_byte[6:0]};
                        if (rx_byte[7])
                        begin
                            phase_next = PH_MASK;
                        end
                        else
                        begin
                            hd_go = 1'b1;
                            hd_lo = {25'd0, rx_byte[6:0]};
                            hd_hi = 1'b0;
                        end
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    len_next    = ext_lo;
                    len_hi_next = ext_hi;
                    if (cnt_reg >= ext_last)
                    begin
                        cnt_next = 3'd0;
                        if (mask_en_reg)
                        begin
                            phase_next = PH_MASK;
                        end
                        else
                        begin
                            hd_go = 1'b1;
                            hd_lo = ext_lo;
                            hd_hi = ext_hi;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (cnt_reg >= MASK_LAST)
                    begin
                        cnt_next = 3'd0;
                        hd_go    = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    pos_next = pos_reg + 2'd1;
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        phase_next  = PH_HDR0;
                        halted_next = halted_reg || fin_halt;
                        cmd.ev      = 1'b1;
                        cmd.code    = fin_code;
                    end
                    cmd_valid  = is_data || (rem_dec == 32'd0);
                    cmd.pv     = is_data;
                    cmd.raw    = is_data ? rx_byte : 8'd0;
                    cmd.mask   = (is_data && mask_en_reg) ? key_byte : 8'd0;
                    cmd.opcode = opcode_reg;
                    cmd.len_lo = len_reg;
                    cmd.len_hi = len_hi_reg;
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            // header complete: length check, empty frame or payload start
            if (hd_go)
            begin
                too_big    = hd_hi || ((hd_lo != 32'd0) && (hd_lo >= max_len_reg));
                cmd_valid  = 1'b1;
                cmd.ev     = 1'b1;
                cmd.opcode = opcode_reg;
                if (too_big)
                begin
                    halted_next = 1'b1;
                    cmd.code    = EVT_TOO_BIG;
                    cmd.len_lo  = hd_lo;
                    cmd.len_hi  = hd_hi;
                end
                else if (hd_lo == 32'd0)
                begin
                    phase_next  = PH_HDR0;
                    halted_next = halted_reg || fin_halt;
                    cmd.code    = fin_code;
                end
                else
                begin
                    cmd_valid  = 1'b0;
                    cmd.ev     = 1'b0;
                    rem_next   = hd_lo;
                    pos_next   = 2'd0;
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= 4'd0;
            mask_en_reg <= 1'b0;
            len_reg     <= 32'd0;
            len_hi_reg  <= 1'b0;
            rem_reg     <= 32'd0;
            cnt_reg     <= 3'd0;
            key_reg     <= 32'd0;
            pos_reg     <= 2'd0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            mask_en_reg <= mask_en_next;
            len_reg     <= len_next;
            len_hi_reg  <= len_hi_next;
            rem_reg     <= rem_next;
            cnt_reg     <= cnt_next;
            key_reg     <= key_next;
            pos_reg     <= pos_next;
            halted_reg  <= halted_next;
        end
    end

    // maximum message length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_fire)
        begin
            max_len_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/wsfr_fifo.sv -----
// ----------------------------------------------------------------------------
// wsfr_fifo
// Short command queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire wsfr_pkg::cmd_t    wr_data,
    input  wire logic              rd_en,
    output wsfr_pkg::cmd_t         rd_data,
    output wsfr_pkg::fifo_stat_t   stat
);
    import wsfr_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign stat.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/wsfr_back.sv -----
// ----------------------------------------------------------------------------
// wsfr_back
// Output stage: unmasks the payload byte, saturates the reported length and
// holds the result in an output register until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wsfr_pkg::cmd_t    q_data,
    input  wire wsfr_pkg::fifo_stat_t q_stat,
    output logic                   q_rd,
    input  wire logic              pop,
    output logic                   empty,
    output logic                   payload_valid,
    output logic [7:0]             payload_byte,
    output logic                   event_valid,
    output logic [2:0]             event_code,
    output logic [3:0]             frame_opcode,
    output logic [31:0]            frame_length
);
    import wsfr_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        pv_reg;
    logic [7:0]  byte_reg;
    logic        ev_reg;
    evt_code_t   code_reg;
    logic [3:0]  opcode_reg;
    logic [31:0] length_reg;
    logic        load;

    // refill the output register when it is free or being taken
    assign load = !q_stat.empty && (!out_valid_reg || pop);
    assign q_rd = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // unmask and saturate into the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pv_reg     <= q_data.pv;
            byte_reg   <= q_data.raw ^ q_data.mask;
            ev_reg     <= q_data.ev;
            code_reg   <= q_data.code;
            opcode_reg <= q_data.opcode;
            length_reg <= q_data.len_hi ? 32'hFFFF_FFFF : q_data.len_lo;
        end
    end

    assign empty         = !out_valid_reg;
    assign payload_valid = pv_reg;
    assign payload_byte  = byte_reg;
    assign event_valid   = ev_reg;
    assign event_code    = code_reg;
    assign frame_opcode  = opcode_reg;
    assign frame_length  = length_reg;

endmodule

`default_nettype wire

// ----- sv/wsfr_checker.sv -----
// ----------------------------------------------------------------------------
// wsfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic        payload_valid,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        event_valid,
    input  wire logic [2:0]  event_code,
    input  wire logic [3:0]  frame_opcode,
    input  wire logic [31:0] frame_length
);
    import wsfr_pkg::*;

    // a waiting result holds until its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(payload_byte) && $stable(event_code)
                              && $stable(frame_length) && $stable(frame_opcode)))
        else $error("result changed while waiting");

    // every shown result carries a byte or an event
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (payload_valid || event_valid))
        else $error("result with neither payload nor event");

    // payload bytes come from text or binary frames only
    a_data_op: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && payload_valid) |-> (frame_opcode == OPC_TEXT || frame_opcode == OPC_BINARY))
        else $error("payload byte from a control frame");

    // idle fields read as zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((payload_valid || payload_byte == 8'd0)
                    && (event_valid || event_code == EVT_DATA)))
        else $error("idle field not zero");

    // event codes stay within the defined set
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_valid) |-> (event_code == EVT_DATA || event_code == EVT_PING
            || event_code == EVT_CLOSE || event_code == EVT_TOO_BIG
            || event_code == EVT_UNSUPPORTED))
        else $error("undefined event code");

endmodule

bind websocket_frame_receiver_core wsfr_checker u_wsfr_checker (.*);

`default_nettype wire

// ----- tb/sv/websocket_frame_receiver_core_test.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_receiver_core_test
// Self-checking bench for the websocket frame receiver. Well-formed frames
// with random opcodes, masks, length encodings and payloads are pushed in. An
// independent parser model predicts every payload byte and frame event, and
// each popped result is compared field by field. Random gaps are used on both
// queue sides. The length limit is changed between drained phases, and the
// run ends on one halting frame followed by ignored noise.
// ----------------------------------------------------------------------------

module websocket_frame_receiver_core_test;

    import wsfr_pkg::*;

    // quiet cycles allowed before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    // how a frame carries its payload length
    typedef enum int {
        ENC_SHORT,
        ENC_16,
        ENC_64
    } len_enc_t;

    // one popped result
    typedef struct packed {
        logic        pv;
        logic [7:0]  data;
        logic        ev;
        logic [2:0]  code;
        logic [3:0]  opcode;
        logic [31:0] length;
    } rx_out_t;

    // parser model plus the queue of results still to come
    class frame_tracker;
        logic [31:0] max_len;
        phase_t      phase;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] len_acc;
        logic [31:0] remaining;
        logic [2:0]  byte_idx;
        logic [31:0] key;
        logic [1:0]  key_pos;
        logic        halted;
        rx_out_t     staged;
        rx_out_t     pending_outputs[$];
        int          errors;
        int          checked;

        function new();
            max_len   = MAX_LEN_RESET;
            phase     = PH_HDR0;
            opcode    = '0;
            masked    = 1'b0;
            len_acc   = '0;
            remaining = '0;
            byte_idx  = '0;
            key       = '0;
            key_pos   = '0;
            halted    = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        function rx_out_t make_result(logic pv, logic [7:0] data, logic ev,
                                      logic [2:0] code, logic [63:0] len);
            rx_out_t r;
            r.pv     = pv;
            r.data   = data;
            r.ev     = ev;
            r.code   = code;
            r.opcode = opcode;
            r.length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
            return r;
        endfunction

        // frame end: event code, back to the header, halt on close or error
        function logic [2:0] end_frame();
            phase = PH_HDR0;
            if (opcode == OPC_TEXT || opcode == OPC_BINARY)
                return EVT_DATA;
            if (opcode == OPC_PING)
                return EVT_PING;
            halted = 1'b1;
            return (opcode == OPC_CLOSE) ? EVT_CLOSE : EVT_UNSUPPORTED;
        endfunction

        // header and key complete: limit check, empty frame or payload start
        function bit header_done();
            if (len_acc != 0 && len_acc >= {32'd0, max_len})
            begin
                halted = 1'b1;
                staged = make_result(1'b0, 8'd0, 1'b1, EVT_TOO_BIG, len_acc);
                return 1'b1;
            end
            if (len_acc == 0)
            begin
                staged = make_result(1'b0, 8'd0, 1'b1, end_frame(), 64'd0);
                return 1'b1;
            end
            remaining = len_acc[31:0];
            key_pos   = '0;
            phase     = PH_PAYLOAD;
            return 1'b0;
        endfunction

        function bit length_done();
            byte_idx = '0;
            if (masked)
            begin
                key   = '0;
                phase = PH_MASK;
                return 1'b0;
            end
            return header_done();
        endfunction

        // advance the model by one accepted byte
        function void note_byte(logic [7:0] b);
            bit         out_now;
            bit         is_data;
            logic       ev;
            logic [7:0] data;
            logic [2:0] code;
            out_now = 1'b0;
            if (halted)
                return;
            case (phase)
                PH_HDR0:
                begin
                    opcode = b[3:0];
                    phase  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked   = b[7];
                    len_acc  = '0;
                    byte_idx = '0;
                    if (b[6:0] == LEN_EXT16)
                        phase = PH_EXT16;
                    else if (b[6:0] == LEN_EXT64)
                        phase = PH_EXT64;
                    else
                    begin
                        len_acc = {57'd0, b[6:0]};
                        out_now = length_done();
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    len_acc = {len_acc[55:0], b};
                    if (byte_idx >= ((phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                        out_now = length_done();
                    else
                        byte_idx = byte_idx + 3'd1;
                end
                PH_MASK:
                begin
                    key = {key[23:0], b};
                    if (byte_idx >= MASK_LAST)
                    begin
                        byte_idx = '0;
                        out_now  = header_done();
                    end
                    else
                        byte_idx = byte_idx + 3'd1;
                end
                PH_PAYLOAD:
                begin
                    data = b;
                    if (masked)
                        data = b ^ 8'(key >> ((3 - key_pos) * 8));
                    key_pos = key_pos + 2'd1;
                    is_data = (opcode == OPC_TEXT || opcode == OPC_BINARY);
                    ev      = 1'b0;
                    code    = EVT_DATA;
                    if (remaining > 0)
                        remaining = remaining - 32'd1;
                    if (remaining == 0)
                    begin
                        code = end_frame();
                        ev   = 1'b1;
                    end
                    if (is_data || ev)
                    begin
                        staged  = make_result(is_data, is_data ? data : 8'd0, ev, code,
                                              len_acc);
                        out_now = 1'b1;
                    end
                end
                default:
                    phase = PH_HDR0;
            endcase
            if (out_now)
                pending_outputs.push_back(staged);
        endfunction

        function bit field_ok(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // compare one popped result with the oldest prediction
        function void check_output(rx_out_t got);
            rx_out_t want;
            bit      ok;
            if (pending_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: expected none actual %0h",
                         $time, got);
                return;
            end
            want = pending_outputs.pop_front();
            ok = field_ok("payload_valid", want.pv, got.pv);
            ok &= field_ok("payload_byte", want.data, got.data);
            ok &= field_ok("event_valid", want.ev, got.ev);
            ok &= field_ok("event_code", want.code, got.code);
            ok &= field_ok("frame_opcode", want.opcode, got.opcode);
            ok &= field_ok("frame_length", want.length, got.length);
            if (!ok)
                errors++;
            checked++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        event_valid;
    logic [2:0]  event_code;
    logic [3:0]  frame_opcode;
    logic [31:0] frame_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'd0;

    frame_tracker sb;
    rx_out_t      popped;
    bit           push_idle = 1'b1;
    bit           pop_idle = 1'b1;
    int           pop_gap = 0;
    int           quiet_cycles = 0;
    int           bytes_sent = 0;
    int           frames_sent = 0;
    int           limit_writes = 0;
    string        halt_kind;

    websocket_frame_receiver_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .event_valid   (event_valid),
        .event_code    (event_code),
        .frame_opcode  (frame_opcode),
        .frame_length  (frame_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check each transfer, then stall for a random count
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                popped.pv     = payload_valid;
                popped.data   = payload_byte;
                popped.ev     = event_valid;
                popped.code   = event_code;
                popped.opcode = frame_opcode;
                popped.length = frame_length;
                sb.check_output(popped);
                pop_gap = pop_idle ? $urandom_range(0, 3) : 0;
                if ($urandom_range(0, 47) == 0)
                    pop_idle = !pop_idle;
            end
            if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("websocket_frame_receiver_core: mismatch");
                $finish;
            end
        end
    end

    // one byte transfer after a random gap; returns on the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = push_idle ? $urandom_range(0, 3) : 0;
        if ($urandom_range(0, 63) == 0)
            push_idle = !push_idle;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    function automatic len_enc_t pick_encoding(longint unsigned len);
        int r;
        if (len > 65535)
            return ENC_64;
        r = $urandom_range(0, 9);
        if (len > 125)
            return (r < 5) ? ENC_16 : ENC_64;
        return (r < 6) ? ENC_SHORT : (r < 8) ? ENC_16 : ENC_64;
    endfunction

    // header, extended length, key and optionally the payload of one frame
    task automatic send_frame(input logic [7:0] first, input longint unsigned len,
                              input len_enc_t enc, input bit masked, input bit with_payload);
        logic [31:0] key;
        logic [63:0] len_bits;
        logic [6:0]  len7;
        key      = $urandom;
        len_bits = len;
        len7     = (enc == ENC_16) ? LEN_EXT16 : (enc == ENC_64) ? LEN_EXT64 : len_bits[6:0];
        send_byte(first);
        send_byte({masked, len7});
        if (enc == ENC_16)
        begin
            send_byte(len_bits[15:8]);
            send_byte(len_bits[7:0]);
        end
        if (enc == ENC_64)
            for (int i = 7; i >= 0; i--)
                send_byte(len_bits[8 * i +: 8]);
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        if (with_payload)
            repeat (len) send_byte(8'($urandom));
        frames_sent++;
    endtask

    // text, binary or ping frame with a length below the limit
    task automatic random_frame(input longint unsigned max_len);
        longint unsigned len;
        int              pick;
        logic [3:0]      op;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 160) : $urandom_range(0, 12);
        if (len > max_len - 1)
            len = max_len - 1;
        pick = $urandom_range(0, 4);
        op   = (pick < 2) ? OPC_TEXT : (pick < 4) ? OPC_BINARY : OPC_PING;
        send_frame({4'($urandom), op}, len, pick_encoding(len),
                   $urandom_range(0, 9) < 7, 1'b1);
    endtask

    task automatic empty_frames(input int count);
        int         pick;
        logic [3:0] op;
        repeat (count)
        begin
            pick = $urandom_range(0, 2);
            op   = (pick == 0) ? OPC_TEXT : (pick == 1) ? OPC_BINARY : OPC_PING;
            send_frame({4'($urandom), op}, 0, pick_encoding(0), 1'($urandom), 1'b1);
        end
    endtask

    // sender pause until every predicted result has been popped
    task automatic drain_results();
        push <= 1'b0;
        while (sb.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.max_len = value;
        limit_writes++;
    endtask

    // last frame: close, length over the limit, or an unsupported opcode
    task automatic halting_frame();
        longint unsigned len;
        logic [63:0]     huge;
        logic [3:0]      op;
        int              kind;
        kind = $urandom_range(0, 2);
        len  = $urandom_range(0, 12);
        if (len > sb.max_len - 1)
            len = sb.max_len - 1;
        if (kind == 0)
        begin
            halt_kind = "close";
            send_frame({4'($urandom), OPC_CLOSE}, len, pick_encoding(len),
                       1'($urandom), 1'b1);
        end
        else if (kind == 1)
        begin
            halt_kind = "length over the limit";
            if ($urandom_range(0, 1) == 0)
            begin
                len = sb.max_len + $urandom_range(0, 200);
                send_frame(8'($urandom), len, pick_encoding(len), 1'($urandom), 1'b0);
            end
            else
            begin
                huge = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
                send_frame(8'($urandom), huge, ENC_64, 1'($urandom), 1'b0);
            end
        end
        else
        begin
            halt_kind = "unsupported opcode";
            do
                op = 4'($urandom);
            while (op == OPC_TEXT || op == OPC_BINARY || op == OPC_CLOSE || op == OPC_PING);
            send_frame({4'($urandom), op}, len, pick_encoding(len), 1'($urandom), 1'b1);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        logic [7:0] opening[16] = '{8'hF1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                                    8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00,
                                    8'hFF, 8'h00, 8'hFF, 8'h00};
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // text frame with all header flag bits set, mask and long form length
        foreach (opening[i])
            send_byte(opening[i]);
        frames_sent++;
        // empty binary frame, empty masked ping
        send_frame({4'h8, OPC_BINARY}, 0, ENC_SHORT, 1'b0, 1'b1);
        send_frame({4'h8, OPC_PING}, 0, ENC_SHORT, 1'b1, 1'b1);

        // reset value of the limit
        while (bytes_sent < 300)
            random_frame(MAX_LEN_RESET);

        // limits of zero and one: only empty frames pass
        write_limit(32'd0);
        empty_frames(6);
        write_limit(32'd1);
        empty_frames(6);

        write_limit(32'hFFFF_FFFF);
        while (bytes_sent < 500)
            random_frame(32'hFFFF_FFFF);

        write_limit(32'($urandom_range(2, 48)));
        while (bytes_sent < 690)
            random_frame(sb.max_len);

        halting_frame();
        // the block drops everything from here on
        repeat (16) send_byte(8'($urandom));

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.pending_outputs.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.pending_outputs.size());
        end

        $display("%0d frames in %0d bytes, %0d results checked, %0d limit writes",
                 frames_sent, bytes_sent, sb.checked, limit_writes);
        $display("final frame halted the parser on %s", halt_kind);
        if (sb.errors == 0)
            $display("websocket_frame_receiver_core: match");
        else
            $display("websocket_frame_receiver_core: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/wsfr_pkg.sv
sv/wsfr_front.sv
sv/wsfr_fifo.sv
sv/wsfr_back.sv
sv/websocket_frame_receiver_core.sv
sv/wsfr_checker.sv
tb/sv/websocket_frame_receiver_core_test.sv
